/* design/efsa_pkg.sv */
`default_nettype none

package efsa_pkg;

    localparam int OUT_SERVER_BITS = 5;
    localparam int OUT_TIME_BITS   = 32;
    localparam int DUR_BITS        = 16;
    localparam int CFG_BITS        = 5;

    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 5'd16;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_JOB   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // Shared control for every cell of the ring.
    typedef struct packed {
        logic shift;
        logic clr;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* design/earliest_free_server_assign.sv */
`default_nettype none

// Channel   Direction  Ports                                          Handshake
// job       in         i_op, i_duration                               start && !busy
// result    out        o_assigned_server, o_next_server,              o_valid strobe
//                      o_next_free_time, o_saturated
// config    in         i_cfg_data                                     i_cfg_valid && o_cfg_ready
//
// For a job, the ring of busy times rotates once past the compare at its head,
// the update state writes the chosen server's new time, and the result follows
// in the next cycle. A clear leaves busy low, so another item may follow at once.
// Reset is synchronous and active low; it zeroes every busy time and sets the
// active server count to 16. The result is a single-cycle strobe and cannot stall.

module earliest_free_server_assign
    import efsa_pkg::*;
#(
    parameter int MAX_SERVERS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_op,
    input  wire logic [DUR_BITS-1:0]        i_duration,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_BITS-1:0]        i_cfg_data,
    output logic                            o_valid,
    output logic [OUT_SERVER_BITS-1:0]      o_assigned_server,
    output logic [OUT_SERVER_BITS-1:0]      o_next_server,
    output logic [OUT_TIME_BITS-1:0]        o_next_free_time,
    output logic                            o_saturated
);

    localparam int IDXW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int LW   = (IDXW + 1 > CFG_BITS) ? IDXW + 1 : CFG_BITS;
    localparam int SW   = ((TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    t_state                  r_state;
    t_state                  n_state;
    logic [CFG_BITS-1:0]     r_active;
    logic [IDXW-1:0]         r_cnt;
    logic [DUR_BITS-1:0]     r_dur;
    logic [TIME_BITS-1:0]    r_t1;
    logic [IDXW-1:0]         r_i1;
    logic [TIME_BITS-1:0]    r_t2;
    logic [IDXW-1:0]         r_i2;
    logic                    r_v2;

    logic                    r_out_valid;
    logic [OUT_SERVER_BITS-1:0] r_out_asg;
    logic [OUT_SERVER_BITS-1:0] r_out_next;
    logic [OUT_TIME_BITS-1:0]   r_out_time;
    logic                       r_out_sat;

    t_cell_ctrl              cell_ctrl;
    logic [TIME_BITS-1:0]    cell_val [MAX_SERVERS];
    logic                    accept;
    logic                    last;
    logic [LW-1:0]           n_eff;
    logic                    head_active;
    logic [TIME_BITS-1:0]    head;
    logic [SW-1:0]           sum;
    logic                    sat;
    logic [TIME_BITS-1:0]    new_time;
    logic                    pick2;
    logic [IDXW-1:0]         next_idx;
    logic [TIME_BITS-1:0]    next_time;
    logic [LW-1:0]           asg_num;
    logic [LW-1:0]           next_num;
    logic [63:0]             next_time_w;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign last        = (r_cnt == IDXW'(MAX_SERVERS - 1));
    assign head        = cell_val[0];

    // A count of zero acts as one, and a count above the ring size as the ring size.
    always_comb begin
        n_eff = (r_active == '0) ? LW'(1) : LW'(r_active);
        if (n_eff > LW'(MAX_SERVERS)) begin
            n_eff = LW'(MAX_SERVERS);
        end
    end

    assign head_active = (LW'(r_cnt) < n_eff);

    assign cell_ctrl.shift = (r_state == S_SCAN);
    assign cell_ctrl.clr   = accept && (i_op == OP_CLEAR);

    for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_ring
        efsa_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_wr       ((r_state == S_UPD) && (r_i1 == IDXW'(g))),
            .i_wr_data  (new_time),
            .i_shift_in (cell_val[(g + 1) % MAX_SERVERS]),
            .o_value    (cell_val[g])
        );
    end

    // New time of the chosen server, clipped at the maximum.
    assign sum      = SW'(r_t1) + SW'(r_dur);
    assign sat      = (sum >= SW'(TMAX));
    assign new_time = sat ? TMAX : sum[TIME_BITS-1:0];

    // The next pick is either the updated server or the best of the other active servers.
    assign pick2     = r_v2 && ((r_t2 < new_time) || ((r_t2 == new_time) && (r_i2 < r_i1)));
    assign next_idx  = pick2 ? r_i2 : r_i1;
    assign next_time = pick2 ? r_t2 : new_time;
    assign asg_num   = LW'(r_i1) + LW'(1);
    assign next_num  = LW'(next_idx) + LW'(1);
    assign next_time_w = 64'(next_time);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_JOB)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            if (r_state == S_SCAN) begin
                r_cnt <= last ? '0 : r_cnt + IDXW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (cell_ctrl.clr || (r_state == S_UPD)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Running best and second best over the servers as they pass the head.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dur <= i_duration;
        end
        if (r_state == S_SCAN) begin
            if (r_cnt == '0) begin
                r_t1 <= head;
                r_i1 <= '0;
                r_v2 <= 1'b0;
            end else if (head_active) begin
                if (head < r_t1) begin
                    r_t2 <= r_t1;
                    r_i2 <= r_i1;
                    r_v2 <= 1'b1;
                    r_t1 <= head;
                    r_i1 <= r_cnt;
                end else if (!r_v2 || (head < r_t2)) begin
                    r_t2 <= head;
                    r_i2 <= r_cnt;
                    r_v2 <= 1'b1;
                end
            end
        end
        if (cell_ctrl.clr) begin
            r_out_asg  <= '0;
            r_out_next <= OUT_SERVER_BITS'(1);
            r_out_time <= '0;
            r_out_sat  <= 1'b0;
        end else if (r_state == S_UPD) begin
            r_out_asg  <= asg_num[OUT_SERVER_BITS-1:0];
            r_out_next <= next_num[OUT_SERVER_BITS-1:0];
            r_out_time <= next_time_w[OUT_TIME_BITS-1:0];
            r_out_sat  <= sat;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_assigned_server = r_out_asg;
    assign o_next_server     = r_out_next;
    assign o_next_free_time  = r_out_time;
    assign o_saturated       = r_out_sat;

    a_upd_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> o_valid)
        else $error("update cycle did not produce a result");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && last) |=> (r_state == S_UPD))
        else $error("ring pass did not end in the update cycle");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_CLEAR)) |=> (o_valid && (o_assigned_server == '0)
            && (o_next_free_time == '0) && !o_saturated))
        else $error("clear did not report an empty assignment");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> !busy)
        else $error("block still busy when a job result is shown");

endmodule

`default_nettype wire

/* design/efsa_cell.sv */
`default_nettype none

module efsa_cell
    import efsa_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctrl           i_ctrl,
    input  wire logic                 i_wr,
    input  wire logic [TIME_BITS-1:0] i_wr_data,
    input  wire logic [TIME_BITS-1:0] i_shift_in,
    output logic      [TIME_BITS-1:0] o_value
);

    logic [TIME_BITS-1:0] r_value;
    logic [TIME_BITS-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.clr) begin
            n_value = '0;
        end else if (i_wr) begin
            n_value = i_wr_data;
        end else if (i_ctrl.shift) begin
            n_value = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

/* tb/earliest_free_server_assign_test.sv */
`default_nettype none

module earliest_free_server_assign_test;
    timeunit 1ns;
    timeprecision 1ps;

    import efsa_pkg::*;

    localparam int SERVERS     = 16;
    localparam int JOB_CYCLES  = SERVERS + 2;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int LONG_JOBS   = 4;

    typedef struct packed {
        logic [OUT_SERVER_BITS-1:0] assigned_server;
        logic [OUT_SERVER_BITS-1:0] next_server;
        logic [OUT_TIME_BITS-1:0]   next_free_time;
        logic                       saturated;
    } t_sched_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic                op;
        logic [DUR_BITS-1:0] duration;
        logic [CFG_BITS-1:0] cfg_value;
        logic                pinned;
        t_sched_result       want;
    } t_stim_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_op;
    logic [DUR_BITS-1:0]        i_duration;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_BITS-1:0]        i_cfg_data;
    logic                       o_valid;
    logic [OUT_SERVER_BITS-1:0] o_assigned_server;
    logic [OUT_SERVER_BITS-1:0] o_next_server;
    logic [OUT_TIME_BITS-1:0]   o_next_free_time;
    logic                       o_saturated;

    // Shadow of the block's state.
    logic [OUT_TIME_BITS-1:0] busy_time [SERVERS];
    logic [CFG_BITS-1:0]      active_count;

    t_sched_result pending_results [$];

    int mismatch_count  = 0;
    int jobs_sent       = 0;
    int clears_sent     = 0;
    int cfg_writes      = 0;
    int saturated_seen  = 0;
    int quiet_cycles    = 0;
    int sender_idle_pct = 0;

    // Expected results are typed in only where they follow at a glance.
    t_stim_row directed_rows [0:22] = '{
        '{ROW_ITEM, OP_JOB,   16'd0,     5'd0,  1'b1, '{5'd1, 5'd1, 32'd0,      1'b0}},
        '{ROW_ITEM, OP_JOB,   16'hFFFF,  5'd0,  1'b1, '{5'd1, 5'd2, 32'd0,      1'b0}},
        '{ROW_ITEM, OP_JOB,   16'hFFFF,  5'd0,  1'b1, '{5'd2, 5'd3, 32'd0,      1'b0}},
        '{ROW_ITEM, OP_JOB,   16'd1234,  5'd0,  1'b0, '0},
        '{ROW_ITEM, OP_CLEAR, 16'hFFFF,  5'd0,  1'b1, '{5'd0, 5'd1, 32'd0,      1'b0}},
        '{ROW_CFG,  OP_CLEAR, 16'd0,     5'd1,  1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'hFFFF,  5'd0,  1'b1, '{5'd1, 5'd1, 32'd65535,  1'b0}},
        '{ROW_ITEM, OP_JOB,   16'hFFFF,  5'd0,  1'b1, '{5'd1, 5'd1, 32'd131070, 1'b0}},
        '{ROW_CFG,  OP_CLEAR, 16'd0,     5'd0,  1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'd5,     5'd0,  1'b1, '{5'd1, 5'd1, 32'd131075, 1'b0}},
        '{ROW_CFG,  OP_CLEAR, 16'd0,     5'd31, 1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'd7,     5'd0,  1'b1, '{5'd2, 5'd3, 32'd0,      1'b0}},
        '{ROW_CFG,  OP_CLEAR, 16'd0,     5'd17, 1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'd9,     5'd0,  1'b0, '0},
        '{ROW_CFG,  OP_CLEAR, 16'd0,     5'd2,  1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'd100,   5'd0,  1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'd200,   5'd0,  1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'd0,     5'd0,  1'b0, '0},
        '{ROW_CFG,  OP_CLEAR, 16'd0,     5'd16, 1'b0, '0},
        '{ROW_ITEM, OP_JOB,   16'd3,     5'd0,  1'b0, '0},
        '{ROW_ITEM, OP_CLEAR, 16'd0,     5'd0,  1'b1, '{5'd0, 5'd1, 32'd0,      1'b0}},
        '{ROW_ITEM, OP_JOB,   16'd0,     5'd0,  1'b1, '{5'd1, 5'd1, 32'd0,      1'b0}},
        '{ROW_ITEM, OP_JOB,   16'h5A5A,  5'd0,  1'b0, '0}
    };

    earliest_free_server_assign u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_duration        (i_duration),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_assigned_server (o_assigned_server),
        .o_next_server     (o_next_server),
        .o_next_free_time  (o_next_free_time),
        .o_saturated       (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    // Lowest-numbered server holding the smallest busy time among the first n.
    function automatic int least_loaded(input int n);
        int best;
        best = 0;
        for (int i = 1; i < n; i++) begin
            if (busy_time[i] < busy_time[best]) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic t_sched_result schedule_item(input logic op,
                                                    input logic [DUR_BITS-1:0] dur);
        t_sched_result r;
        int n;
        int k;
        logic [OUT_TIME_BITS:0] sum;
        r = '0;
        n = (active_count == 0) ? 1 : ((active_count > SERVERS) ? SERVERS : active_count);
        if (op == OP_CLEAR) begin
            foreach (busy_time[i]) begin
                busy_time[i] = '0;
            end
        end else begin
            k = least_loaded(n);
            sum = {1'b0, busy_time[k]} + (OUT_TIME_BITS + 1)'(dur);
            busy_time[k] = sum[OUT_TIME_BITS] ? '1 : sum[OUT_TIME_BITS-1:0];
            r.saturated = &busy_time[k];
            r.assigned_server = OUT_SERVER_BITS'(k + 1);
        end
        k = least_loaded(n);
        r.next_server = OUT_SERVER_BITS'(k + 1);
        r.next_free_time = busy_time[k];
        return r;
    endfunction

    // Returns at the rising edge that accepted the item, with start still high.
    task automatic send_item(input logic op, input logic [DUR_BITS-1:0] dur,
                             input logic pinned, input t_sched_result want);
        t_sched_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_duration <= dur;
        do @(posedge i_clk); while (busy);
        predicted = schedule_item(op, dur);
        pending_results.push_back(pinned ? want : predicted);
        if (op == OP_CLEAR) begin
            clears_sent++;
        end else begin
            jobs_sent++;
        end
    endtask

    // The register is written only once every result is in and the block is idle.
    task automatic write_active(input logic [CFG_BITS-1:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) begin
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        active_count = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_job();
        logic                op;
        logic [DUR_BITS-1:0] dur;
        op = ($urandom_range(24) == 0) ? OP_CLEAR : OP_JOB;
        case ($urandom_range(9)) inside
            0:       dur = '0;
            1:       dur = '1;
            [2:4]:   dur = DUR_BITS'($urandom_range(15));
            default: dur = DUR_BITS'($urandom_range(65535));
        endcase
        send_item(op, dur, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, server", 32'd0,
                                32'(o_assigned_server));
            end else begin
                want = pending_results.pop_front();
                if (o_assigned_server !== want.assigned_server) begin
                    report_mismatch("assigned_server", 32'(want.assigned_server),
                                    32'(o_assigned_server));
                end
                if (o_next_server !== want.next_server) begin
                    report_mismatch("next_server", 32'(want.next_server),
                                    32'(o_next_server));
                end
                if (o_next_free_time !== want.next_free_time) begin
                    report_mismatch("next_free_time", want.next_free_time, o_next_free_time);
                end
                if (o_saturated !== want.saturated) begin
                    report_mismatch("saturated", 32'(want.saturated), 32'(o_saturated));
                end
                if (want.saturated) begin
                    saturated_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_BITS-1:0] phase_cfg [PHASES];
        int                  phase_idle [3];
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_CLEAR;
        i_duration  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = ACTIVE_RESET;
        foreach (busy_time[i]) begin
            busy_time[i] = '0;
        end
        active_count = ACTIVE_RESET;
        phase_cfg  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8, 5'd16};
        phase_idle = '{0, 88, 18};
        phase_cfg[5] = CFG_BITS'($urandom_range(31));
        phase_cfg[6] = CFG_BITS'($urandom_range(1, 16));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_active(directed_rows[r].cfg_value);
            end else begin
                send_item(directed_rows[r].op, directed_rows[r].duration,
                          directed_rows[r].pinned, directed_rows[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_active(phase_cfg[p]);
            // Part of each phase runs with no gaps at all.
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sender_idle_pct = (i < PHASE_ITEMS / 4) ? 0 : phase_idle[p % 3];
                send_random_job();
            end
        end

        // A single server takes a few of the longest jobs in a row.
        sender_idle_pct = 0;
        write_active(5'd1);
        send_item(OP_CLEAR, '0, 1'b0, '0);
        repeat (LONG_JOBS) send_item(OP_JOB, '1, 1'b0, '0);
        send_item(OP_JOB, '0, 1'b0, '0);
        repeat (3) send_random_job();
        write_active(5'd16);
        sender_idle_pct = 18;
        repeat (20) send_random_job();
        send_item(OP_CLEAR, '0, 1'b0, '0);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2 * JOB_CYCLES) @(negedge i_clk);

        $display("ran %0d jobs and %0d clears across %0d server-count writes",
                 jobs_sent, clears_sent, cfg_writes);
        $display("%0d results showed a saturated busy time, %0d mismatches",
                 saturated_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/efsa_pkg.sv
design/efsa_cell.sv
design/earliest_free_server_assign.sv
tb/earliest_free_server_assign_test.sv
